// ----- rtl/zba_pkg.sv -----
// ----------------------------------------------------------------------------
// Zone bitmap allocator package
// Shared constants, result codes and the command and status groups that pass
// between the allocator's controller and its datapath.
// ----------------------------------------------------------------------------
package zba_pkg;

   // Fixed field widths.
   localparam int DATA_W    = 64;
   localparam int ZONE_W    = 16;
   localparam int SUM_W     = ZONE_W + 1;
   localparam int INDEX_W   = 10;
   localparam int STATUS_W  = 2;
   localparam int MASK_W    = 8;
   localparam int CSR_W     = 32;
   localparam int CSR_ADDR_W = 4;

   // Request commands.
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_ALLOC = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_LOADED = 2'd3;

   // Register indexes (word address of the register file).
   localparam logic [1:0] CSR_FIRST_DATA_ZONE = 2'd0;
   localparam logic [1:0] CSR_ZONE_COUNT      = 2'd1;
   localparam logic [1:0] CSR_PRESENT_MASK    = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_step;   // write zero at the sweep address and advance
      logic load;         // write the request word and report it loaded
      logic scan_init;    // rewind the scan to word zero of block zero
      logic scan;         // issue a read or capture a word with a clear bit
      logic find_byte;    // locate the lowest byte holding a clear bit
      logic set_bit;      // set the lowest clear bit and mark the block dirty
      logic add;          // form bit offset plus first data zone
      logic finish;       // range check and publish the allocation result
      logic full;         // publish a map full result
   } zba_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;   // the sweep is at the last word
      logic hit;          // the word returned by the memory has a clear bit
      logic exhausted;    // no present block left and no read outstanding
   } zba_stat_type;

endpackage

// ----- rtl/zba_ram.sv -----
// ----------------------------------------------------------------------------
// Zone bitmap allocator RAM
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module zba_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/zba_ctrl.sv -----
// ----------------------------------------------------------------------------
// Zone bitmap allocator controller
// Sequences the clearing sweep, word loads and the first-fit allocation scan,
// and drives the datapath through one command group.
// ----------------------------------------------------------------------------
module zba_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 req_cmd,
   input  zba_pkg::zba_stat_type stat,
   output zba_pkg::zba_cmd_type  cmd,
   output logic                 busy
);

   import zba_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_BYTE,
      S_BIT,
      S_ADD,
      S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               if (req_cmd == CMD_LOAD) begin
                  cmd.load = 1'b1;
               end else begin
                  cmd.scan_init = 1'b1;
                  state_in      = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.hit) begin
               state_in = S_BYTE;
            end else if (stat.exhausted) begin
               cmd.full = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_BYTE: begin
            cmd.find_byte = 1'b1;
            state_in      = S_BIT;
         end
         S_BIT: begin
            cmd.set_bit = 1'b1;
            state_in    = S_ADD;
         end
         S_ADD: begin
            cmd.add  = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and the registered busy flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         busy_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != S_IDLE);
      end
   end

   assign busy = busy_ff;

endmodule

// ----- rtl/zba_dpath.sv -----
// ----------------------------------------------------------------------------
// Zone bitmap allocator datapath
// Holds the bitmap memory, the scan counters, the lowest clear bit search,
// the zone arithmetic and the result registers.
// ----------------------------------------------------------------------------
module zba_dpath #(
   parameter int MAP_BLOCKS     = 8,
   parameter int BITS_PER_BLOCK = 8192
) (
   input  logic                           clock,
   input  logic                           reset,
   input  zba_pkg::zba_cmd_type            cmd,
   output zba_pkg::zba_stat_type           stat,
   input  logic [zba_pkg::INDEX_W-1:0]    req_word_index,
   input  logic [zba_pkg::DATA_W-1:0]     req_word_data,
   input  logic [zba_pkg::ZONE_W-1:0]     first_data_zone,
   input  logic [zba_pkg::ZONE_W-1:0]     zone_count,
   input  logic [zba_pkg::MASK_W-1:0]     map_present_mask,
   output logic                           rsp_strobe,
   output logic [zba_pkg::ZONE_W-1:0]     rsp_zone_number,
   output logic [zba_pkg::STATUS_W-1:0]   rsp_status,
   output logic [zba_pkg::MASK_W-1:0]     rsp_dirty_mask
);

   import zba_pkg::*;

   localparam int WORDS_PER_BLOCK = BITS_PER_BLOCK / DATA_W;
   localparam int TOTAL_WORDS     = MAP_BLOCKS * WORDS_PER_BLOCK;
   localparam int AW    = (TOTAL_WORDS > 1) ? $clog2(TOTAL_WORDS) : 1;
   localparam int WW    = (WORDS_PER_BLOCK > 1) ? $clog2(WORDS_PER_BLOCK) : 1;
   localparam int BW    = $clog2(MAP_BLOCKS + 1);
   localparam int OFF_W = AW + 6;

   // Scan and sweep counters.
   logic [AW-1:0]      addr_ff, addr_in;
   logic [WW-1:0]      word_ff, word_in;
   logic [BW-1:0]      blk_ff, blk_in;
   // Tags travelling with the outstanding read.
   logic               rd_valid_ff, rd_valid_in;
   logic [AW-1:0]      rd_addr_ff, rd_addr_in;
   logic [BW-1:0]      rd_blk_ff, rd_blk_in;
   // Captured word and search results.
   logic [DATA_W-1:0]  hit_word_ff, hit_word_in;
   logic [AW-1:0]      hit_addr_ff, hit_addr_in;
   logic [BW-1:0]      hit_blk_ff, hit_blk_in;
   logic [2:0]         byte_sel_ff, byte_sel_in;
   logic [7:0]         byte_val_ff, byte_val_in;
   logic [OFF_W-1:0]   offset_ff, offset_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [MASK_W-1:0]  dirty_ff, dirty_in;
   // Result registers.
   logic               strobe_ff, strobe_in;
   logic [ZONE_W-1:0]  zone_ff, zone_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   // Memory ports and intermediate terms.
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [DATA_W-1:0]  wr_data;
   logic               rd_en;
   logic [DATA_W-1:0]  rd_data;
   logic [MAP_BLOCKS:0] present_vec;
   logic               issue_done;
   logic               blk_present;
   logic               hit;
   logic               load_in_range;
   logic [2:0]         bit_c;
   logic [5:0]         bit_pos;
   logic [DATA_W-1:0]  set_word;
   logic               range_bad;

   zba_ram #(
      .WIDTH (DATA_W),
      .DEPTH (TOTAL_WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   // Scan status. A block index equal to MAP_BLOCKS marks the end of the map.
   always_comb begin
      present_vec     = {1'b0, map_present_mask[MAP_BLOCKS-1:0]};
      issue_done      = (blk_ff == BW'(MAP_BLOCKS));
      blk_present     = present_vec[blk_ff];
      hit             = rd_valid_ff && (rd_data != '1);
      stat.hit        = hit;
      stat.exhausted  = issue_done && !rd_valid_ff;
      stat.clear_last = (addr_ff == AW'(TOTAL_WORDS - 1));
      rd_en           = cmd.scan && !hit && !issue_done && blk_present;
      load_in_range   = (32'(req_word_index) < TOTAL_WORDS);
   end

   // Lowest clear bit within the selected byte, then the updated word.
   always_comb begin
      bit_c = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (!byte_val_ff[i]) begin
            bit_c = 3'(i);
         end
      end
      bit_pos  = {byte_sel_ff, bit_c};
      set_word = hit_word_ff | (64'd1 << bit_pos);
   end

   // Memory write port: clearing sweep, word load or bit set.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = addr_ff;
      wr_data = '0;
      if (cmd.clear_step) begin
         wr_en = 1'b1;
      end else if (cmd.load) begin
         wr_en   = load_in_range;
         wr_addr = AW'(req_word_index);
         wr_data = req_word_data;
      end else if (cmd.set_bit) begin
         wr_en   = 1'b1;
         wr_addr = hit_addr_ff;
         wr_data = set_word;
      end
   end

   // Next values of the counters and the search registers.
   always_comb begin
      addr_in     = addr_ff;
      word_in     = word_ff;
      blk_in      = blk_ff;
      rd_valid_in = 1'b0;
      rd_addr_in  = rd_addr_ff;
      rd_blk_in   = rd_blk_ff;
      hit_word_in = hit_word_ff;
      hit_addr_in = hit_addr_ff;
      hit_blk_in  = hit_blk_ff;
      byte_sel_in = byte_sel_ff;
      byte_val_in = byte_val_ff;
      offset_in   = offset_ff;
      sum_in      = sum_ff;
      dirty_in    = dirty_ff;

      if (cmd.clear_step) begin
         addr_in = addr_ff + AW'(1);
      end

      if (cmd.scan_init) begin
         addr_in = '0;
         word_in = '0;
         blk_in  = '0;
      end

      // One read per cycle over present blocks; absent blocks are stepped over.
      if (cmd.scan) begin
         if (hit) begin
            hit_word_in = rd_data;
            hit_addr_in = rd_addr_ff;
            hit_blk_in  = rd_blk_ff;
         end else if (!issue_done) begin
            if (!blk_present) begin
               addr_in = addr_ff + AW'(WORDS_PER_BLOCK);
               blk_in  = blk_ff + BW'(1);
            end else begin
               rd_valid_in = 1'b1;
               rd_addr_in  = addr_ff;
               rd_blk_in   = blk_ff;
               addr_in     = addr_ff + AW'(1);
               if (word_ff == WW'(WORDS_PER_BLOCK - 1)) begin
                  word_in = '0;
                  blk_in  = blk_ff + BW'(1);
               end else begin
                  word_in = word_ff + WW'(1);
               end
            end
         end
      end

      // Lowest byte of the captured word that is not all ones.
      if (cmd.find_byte) begin
         byte_sel_in = 3'd0;
         byte_val_in = hit_word_ff[7:0];
         for (int i = 7; i >= 0; i--) begin
            if (hit_word_ff[8*i +: 8] != 8'hFF) begin
               byte_sel_in = 3'(i);
               byte_val_in = hit_word_ff[8*i +: 8];
            end
         end
      end

      if (cmd.set_bit) begin
         offset_in = {hit_addr_ff, bit_pos};
         for (int k = 0; k < MASK_W; k++) begin
            if (k < MAP_BLOCKS && hit_blk_ff == BW'(k)) begin
               dirty_in[k] = 1'b1;
            end
         end
      end

      if (cmd.add) begin
         sum_in = SUM_W'(offset_ff) + SUM_W'(first_data_zone);
      end
   end

   // Result formation. The zone is the sum less one; a sum of zero or one
   // beyond the zone count is out of range.
   always_comb begin
      range_bad = (sum_ff == '0) || (sum_ff > {1'b0, zone_count});
      strobe_in = 1'b0;
      zone_in   = zone_ff;
      status_in = status_ff;
      if (cmd.load) begin
         strobe_in = 1'b1;
         zone_in   = '0;
         status_in = STATUS_LOADED;
      end else if (cmd.full) begin
         strobe_in = 1'b1;
         zone_in   = '0;
         status_in = STATUS_FULL;
      end else if (cmd.finish) begin
         strobe_in = 1'b1;
         if (range_bad) begin
            zone_in   = '0;
            status_in = STATUS_RANGE;
         end else begin
            zone_in   = ZONE_W'(sum_ff - SUM_W'(1));
            status_in = STATUS_OK;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff     <= '0;
         word_ff     <= '0;
         blk_ff      <= '0;
         rd_valid_ff <= 1'b0;
         dirty_ff    <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         addr_ff     <= addr_in;
         word_ff     <= word_in;
         blk_ff      <= blk_in;
         rd_valid_ff <= rd_valid_in;
         dirty_ff    <= dirty_in;
         strobe_ff   <= strobe_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rd_addr_ff  <= rd_addr_in;
      rd_blk_ff   <= rd_blk_in;
      hit_word_ff <= hit_word_in;
      hit_addr_ff <= hit_addr_in;
      hit_blk_ff  <= hit_blk_in;
      byte_sel_ff <= byte_sel_in;
      byte_val_ff <= byte_val_in;
      offset_ff   <= offset_in;
      sum_ff      <= sum_in;
      zone_ff     <= zone_in;
      status_ff   <= status_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_zone_number = zone_ff;
   assign rsp_status      = status_ff;
   assign rsp_dirty_mask  = dirty_ff;

endmodule

// ----- rtl/zone_bitmap_allocator.sv -----
// ----------------------------------------------------------------------------
// Zone bitmap allocator
// First-fit zone allocator over a free-zone bitmap held in a word memory, with
// an APB-style register port for the zone numbering and the present mask.
// ----------------------------------------------------------------------------
// A load reports in the cycle after its transfer. An allocation scans the present
// blocks word by word, stepping over absent ones, then picks the byte and bit, sets
// it, adds the first data zone and reports; an empty search reports a full map.
// Throughput: one item at a time, paced by the single read port; start may be
// raised in the result cycle. Reset: a clearing sweep zeroes one bitmap word per
// cycle with busy high; register writes are taken.
module zone_bitmap_allocator #(
   parameter int MAP_BLOCKS     = 8,
   parameter int BITS_PER_BLOCK = 8192
) (
   input  logic                           clock,
   input  logic                           reset,
   // Request transfer.
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_cmd,
   input  logic [zba_pkg::INDEX_W-1:0]    req_word_index,
   input  logic [zba_pkg::DATA_W-1:0]     req_word_data,
   // Result transfer.
   output logic                           rsp_strobe,
   output logic [zba_pkg::ZONE_W-1:0]     rsp_zone_number,
   output logic [zba_pkg::STATUS_W-1:0]   rsp_status,
   output logic [zba_pkg::MASK_W-1:0]     rsp_dirty_mask,
   // Register port.
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [zba_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [zba_pkg::CSR_W-1:0]      pwdata,
   output logic [zba_pkg::CSR_W-1:0]      prdata,
   output logic                           pready
);

   import zba_pkg::*;

   logic [ZONE_W-1:0] first_data_zone_ff;
   logic [ZONE_W-1:0] zone_count_ff;
   logic [MASK_W-1:0] present_mask_ff;
   logic              csr_write;
   zba_cmd_type       cmd;
   zba_stat_type      stat;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   // Register writes, decoded on the word address.
   always_ff @(posedge clock) begin
      if (reset) begin
         first_data_zone_ff <= '0;
         zone_count_ff      <= '0;
         present_mask_ff    <= '1;
      end else if (csr_write) begin
         case (paddr[3:2])
            CSR_FIRST_DATA_ZONE: first_data_zone_ff <= pwdata[ZONE_W-1:0];
            CSR_ZONE_COUNT:      zone_count_ff      <= pwdata[ZONE_W-1:0];
            CSR_PRESENT_MASK:    present_mask_ff    <= pwdata[MASK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      case (paddr[3:2])
         CSR_FIRST_DATA_ZONE: prdata = CSR_W'(first_data_zone_ff);
         CSR_ZONE_COUNT:      prdata = CSR_W'(zone_count_ff);
         CSR_PRESENT_MASK:    prdata = CSR_W'(present_mask_ff);
         default:             prdata = '0;
      endcase
   end

   zba_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_cmd),
      .stat    (stat),
      .cmd     (cmd),
      .busy    (busy)
   );

   zba_dpath #(
      .MAP_BLOCKS     (MAP_BLOCKS),
      .BITS_PER_BLOCK (BITS_PER_BLOCK)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_word_index   (req_word_index),
      .req_word_data    (req_word_data),
      .first_data_zone  (first_data_zone_ff),
      .zone_count       (zone_count_ff),
      .map_present_mask (present_mask_ff),
      .rsp_strobe       (rsp_strobe),
      .rsp_zone_number  (rsp_zone_number),
      .rsp_status       (rsp_status),
      .rsp_dirty_mask   (rsp_dirty_mask)
   );

endmodule

// ----- verif/zone_bitmap_allocator_tb.sv -----
// ----------------------------------------------------------------------------
// Zone bitmap allocator testbench
// Sends load and allocate requests through the start/busy handshake. A shadow
// copy of the free-zone bitmap, the dirty blocks and the registers predicts
// every result, and each reported zone, status and dirty mask is checked in
// order. Directed tests cover the corner cases first. Randomised phases then
// vary the register settings between transfers.
// ----------------------------------------------------------------------------
module zone_bitmap_allocator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import zba_pkg::*;

   localparam int MAP_BLOCKS      = 8;
   localparam int BITS_PER_BLOCK  = 8192;
   localparam int WORDS_PER_BLOCK = BITS_PER_BLOCK / DATA_W;
   localparam int MAP_WORDS       = MAP_BLOCKS * WORDS_PER_BLOCK;
   localparam int SCAN_LATENCY    = MAP_WORDS + MAP_BLOCKS + 5;
   localparam int TARGET_ITEMS    = 580;
   localparam int NO_FREE_ZONE    = -1000000;
   localparam longint CYCLE_LIMIT = 3_000_000;
   localparam logic [DATA_W-1:0] ALL_ONES = '1;

   typedef struct packed {
      logic [ZONE_W-1:0]   zone;
      logic [STATUS_W-1:0] status;
      logic [MASK_W-1:0]   dirty;
   } zone_reply_type;

   logic                  clock;
   logic                  reset          = 1'b1;
   logic                  start          = 1'b0;
   logic                  busy;
   logic                  req_cmd        = CMD_LOAD;
   logic [INDEX_W-1:0]    req_word_index = '0;
   logic [DATA_W-1:0]     req_word_data  = '0;
   logic                  rsp_strobe;
   logic [ZONE_W-1:0]     rsp_zone_number;
   logic [STATUS_W-1:0]   rsp_status;
   logic [MASK_W-1:0]     rsp_dirty_mask;
   logic                  psel           = 1'b0;
   logic                  penable        = 1'b0;
   logic                  pwrite         = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr          = '0;
   logic [CSR_W-1:0]      pwdata         = '0;
   logic [CSR_W-1:0]      prdata;
   logic                  pready;

   // Shadow copy of the allocator state and its registers.
   logic [DATA_W-1:0] shadow_map [MAP_WORDS];
   logic [MASK_W-1:0] shadow_dirty;
   logic [ZONE_W-1:0] cfg_first_zone;
   logic [ZONE_W-1:0] cfg_zone_count;
   logic [MASK_W-1:0] cfg_present;

   zone_reply_type replies_due [$];
   zone_reply_type want_reply;
   int          fail_count  = 0;
   int          items_sent  = 0;
   bit          sender_gaps = 1'b1;
   longint      cycle_count = 0;

   zone_bitmap_allocator #(
      .MAP_BLOCKS     (MAP_BLOCKS),
      .BITS_PER_BLOCK (BITS_PER_BLOCK)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_word_index  (req_word_index),
      .req_word_data   (req_word_data),
      .rsp_strobe      (rsp_strobe),
      .rsp_zone_number (rsp_zone_number),
      .rsp_status      (rsp_status),
      .rsp_dirty_mask  (rsp_dirty_mask),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Runaway guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic note_failure(input string what, input longint expected_val,
                               input longint actual_val);
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what,
               expected_val, actual_val);
   endtask

   // Each result transfer is compared with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (replies_due.size() == 0) begin
            fail_count++;
            $display("%0t: result transfer with none expected, zone %0d status %0d",
                     $time, rsp_zone_number, rsp_status);
         end else begin
            want_reply = replies_due.pop_front();
            if (rsp_zone_number !== want_reply.zone)
               note_failure("zone number", longint'(want_reply.zone),
                            longint'(rsp_zone_number));
            if (rsp_status !== want_reply.status)
               note_failure("status", longint'(want_reply.status), longint'(rsp_status));
            if (rsp_dirty_mask !== want_reply.dirty)
               note_failure("dirty mask", longint'(want_reply.dirty),
                            longint'(rsp_dirty_mask));
         end
      end
   end

   // Lowest clear bit among the present blocks, in block order.
   function automatic bit find_free(output int word, output int pos);
      word = 0;
      pos  = 0;
      for (int k = 0; k < MAP_BLOCKS; k++) begin
         if (cfg_present[k]) begin
            for (int w = k * WORDS_PER_BLOCK; w < (k + 1) * WORDS_PER_BLOCK; w++) begin
               if (shadow_map[w] != ALL_ONES) begin
                  word = w;
                  for (int b = DATA_W - 1; b >= 0; b--)
                     if (!shadow_map[w][b]) pos = b;
                  return 1'b1;
               end
            end
         end
      end
      return 1'b0;
   endfunction

   // Zone number that the next allocation would produce, before range checks.
   function automatic int next_zone_number();
      int word;
      int pos;
      if (!find_free(word, pos)) return NO_FREE_ZONE;
      return word * DATA_W + pos + int'(cfg_first_zone) - 1;
   endfunction

   // Applies one request to the shadow state and returns its result.
   function automatic zone_reply_type compute_reply(input logic cmd,
                                                    input logic [INDEX_W-1:0] index,
                                                    input logic [DATA_W-1:0] data);
      zone_reply_type r;
      int          word;
      int          pos;
      int          num;
      r.zone = '0;
      if (cmd == CMD_LOAD) begin
         // An index beyond the map writes nothing but still reports a load.
         if (index < MAP_WORDS) shadow_map[index] = data;
         r.status = STATUS_LOADED;
      end else if (!find_free(word, pos)) begin
         r.status = STATUS_FULL;
      end else begin
         // The bit stays taken even when the zone number is out of range.
         shadow_map[word][pos] = 1'b1;
         shadow_dirty[word / WORDS_PER_BLOCK] = 1'b1;
         num = word * DATA_W + pos + int'(cfg_first_zone) - 1;
         if (num < 0 || num >= int'(cfg_zone_count)) begin
            r.status = STATUS_RANGE;
         end else begin
            r.zone   = num[ZONE_W-1:0];
            r.status = STATUS_OK;
         end
      end
      r.dirty = shadow_dirty;
      return r;
   endfunction

   // Mostly back-to-back, sometimes short gaps, now and then a long one.
   function automatic int pick_gap();
      int roll;
      if (!sender_gaps) return 0;
      roll = $urandom_range(99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // One request transfer. Start stays high when the next one follows at once.
   task automatic issue_request(input logic cmd, input logic [INDEX_W-1:0] index,
                                input logic [DATA_W-1:0] data);
      int gap;
      req_cmd        <= cmd;
      req_word_index <= index;
      req_word_data  <= data;
      start          <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      replies_due.push_back(compute_reply(cmd, index, data));
      items_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic issue_alloc();
      logic [INDEX_W-1:0] index;
      logic [DATA_W-1:0]  data;
      index = INDEX_W'($urandom_range(MAP_WORDS - 1));
      data  = {$urandom, $urandom};
      issue_request(CMD_ALLOC, index, data);
   endtask

   task automatic wait_for_replies();
      start <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
   endtask

   // Register write, then read back, then the port returns to idle.
   task automatic write_reg(input logic [1:0] index, input logic [CSR_W-1:0] value);
      wait_for_replies();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (index)
         CSR_FIRST_DATA_ZONE: cfg_first_zone = value[ZONE_W-1:0];
         CSR_ZONE_COUNT:      cfg_zone_count = value[ZONE_W-1:0];
         CSR_PRESENT_MASK:    cfg_present    = value[MASK_W-1:0];
         default: ;
      endcase
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== value) note_failure("register read", longint'(value), longint'(prdata));
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input int first_zone, input int zone_count,
                             input int present);
      write_reg(CSR_FIRST_DATA_ZONE, first_zone);
      write_reg(CSR_ZONE_COUNT, zone_count);
      write_reg(CSR_PRESENT_MASK, present);
   endtask

   // Load index biased towards the first words of a present block.
   function automatic logic [INDEX_W-1:0] pick_index();
      int blk;
      if ($urandom_range(99) >= 65) return INDEX_W'($urandom_range(MAP_WORDS - 1));
      blk = $urandom_range(MAP_BLOCKS - 1);
      for (int t = 0; t < MAP_BLOCKS && !cfg_present[blk]; t++)
         blk = (blk + 1) % MAP_BLOCKS;
      return INDEX_W'(blk * WORDS_PER_BLOCK + $urandom_range(3));
   endfunction

   function automatic logic [DATA_W-1:0] pick_word();
      int roll;
      roll = $urandom_range(99);
      if (roll < 30) return ALL_ONES;
      if (roll < 45) return '0;
      if (roll < 75) return {$urandom, $urandom};
      return ALL_ONES & ~(64'd1 << $urandom_range(DATA_W - 1));
   endfunction

   // With the reset settings every allocation is beyond the zone count, and
   // the very first one would even give a negative zone number.
   task automatic test_negative_zone();
      issue_alloc();
      issue_alloc();
   endtask

   // Loads at the index and data extremes, and first-fit across words.
   task automatic test_first_fit();
      set_config(1, 65535, 255);
      issue_request(CMD_ALLOC, '0, '0);
      issue_request(CMD_LOAD, 10'd0, ALL_ONES);
      issue_request(CMD_LOAD, 10'd1, 64'h7FFF_FFFF_FFFF_FFFF);
      issue_request(CMD_ALLOC, '0, '0);
      issue_request(CMD_LOAD, 10'd1023, '0);
      issue_request(CMD_LOAD, 10'd512, 64'hAAAA_AAAA_AAAA_AAAA);
      issue_request(CMD_ALLOC, '0, '0);
      issue_request(CMD_ALLOC, 10'd1023, ALL_ONES);
   endtask

   // No block present gives a full map; absent blocks are skipped.
   task automatic test_present_mask();
      write_reg(CSR_PRESENT_MASK, 32'h00);
      issue_alloc();
      write_reg(CSR_PRESENT_MASK, 32'h80);
      issue_alloc();
      write_reg(CSR_PRESENT_MASK, 32'h24);
      issue_alloc();
   endtask

   // Zone numbers just below and at the zone count, and a zero zone count.
   task automatic test_zone_count_limit();
      set_config(65535, 65535, 255);
      issue_alloc();
      write_reg(CSR_FIRST_DATA_ZONE, 0);
      write_reg(CSR_ZONE_COUNT, next_zone_number() + 1);
      issue_alloc();
      issue_alloc();
      set_config(1, 0, 255);
      issue_alloc();
   endtask

   // Fills one block completely so that allocation reports a full map, then
   // frees a single bit and allocates it.
   task automatic test_block_fill();
      int blk;
      int word;
      blk = $urandom_range(MAP_BLOCKS - 1);
      set_config($urandom_range(255), 65535, 1 << blk);
      for (int w = 0; w < WORDS_PER_BLOCK; w++)
         issue_request(CMD_LOAD, INDEX_W'(blk * WORDS_PER_BLOCK + w), ALL_ONES);
      issue_alloc();
      issue_alloc();
      word = blk * WORDS_PER_BLOCK + $urandom_range(WORDS_PER_BLOCK - 1);
      issue_request(CMD_LOAD, INDEX_W'(word),
                    ALL_ONES & ~(64'd1 << $urandom_range(DATA_W - 1)));
      issue_alloc();
      issue_alloc();
   endtask

   // Random settings per phase, then a mix of loads and allocations.
   task automatic test_random_phases();
      int roll;
      int first_zone;
      int present;
      int zone_count;
      int next_zone;
      int count;
      while (items_sent < TARGET_ITEMS) begin
         sender_gaps = ($urandom_range(3) != 0);
         roll = $urandom_range(99);
         if (roll < 25) first_zone = 0;
         else if (roll < 35) first_zone = 65535;
         else if (roll < 75) first_zone = $urandom_range(255);
         else first_zone = $urandom_range(65535);
         roll = $urandom_range(99);
         if (roll < 20) present = 8'hFF;
         else if (roll < 25) present = 8'h00;
         else if (roll < 35) present = 1 << $urandom_range(MAP_BLOCKS - 1, 4);
         else present = $urandom_range(255);
         write_reg(CSR_FIRST_DATA_ZONE, first_zone);
         write_reg(CSR_PRESENT_MASK, present);
         // Often put the zone count at or just above the next allocation.
         next_zone = next_zone_number();
         roll = $urandom_range(99);
         if (roll < 15) zone_count = 65535;
         else if (roll < 20) zone_count = 0;
         else if (roll < 65 && next_zone != NO_FREE_ZONE) begin
            zone_count = next_zone + $urandom_range(40);
            if (zone_count > 65535) zone_count = 65535;
            if (zone_count < 0) zone_count = 0;
         end else zone_count = $urandom_range(65535);
         write_reg(CSR_ZONE_COUNT, zone_count);
         count = $urandom_range(40, 12);
         for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 55) issue_alloc();
            else issue_request(CMD_LOAD, pick_index(), pick_word());
         end
      end
   endtask

   initial begin
      for (int i = 0; i < MAP_WORDS; i++) shadow_map[i] = '0;
      shadow_dirty   = '0;
      cfg_first_zone = '0;
      cfg_zone_count = '0;
      cfg_present    = 8'hFF;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_negative_zone();
      test_first_fit();
      test_present_mask();
      test_zone_count_limit();
      test_block_fill();
      test_random_phases();
      // Drain, then give any stray result time to show up.
      wait_for_replies();
      repeat (SCAN_LATENCY + 64) @(posedge clock);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
